// File: rtl/core/ehc_pkg.sv
// shared types and constants for the ethernet header classifier
package ehc_pkg;

  localparam int MAX_FRAME_BYTES = 2047;
  localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 1);

  localparam logic [15:0] TYPE_IPV4 = 16'h0800;
  localparam logic [15:0] TYPE_ARP  = 16'h0806;
  localparam logic [15:0] LLC_LIMIT = 16'd1500;
  localparam logic [7:0]  PROTO_ICMP = 8'd1;

  typedef enum logic [2:0] {
    FC_LLC   = 3'd0,
    FC_IPV4  = 3'd1,
    FC_ARP   = 3'd2,
    FC_OTHER = 3'd3,
    FC_TRUNC = 3'd4
  } frame_class_t;

  typedef enum logic [2:0] {
    ICMP_ECHO_REQ     = 3'd0,
    ICMP_ECHO_REPLY   = 3'd1,
    ICMP_UNREACH_LOW  = 3'd2,
    ICMP_UNREACH_HIGH = 3'd3,
    ICMP_TIME_EXCEED  = 3'd4,
    ICMP_OTHER        = 3'd5
  } icmp_class_t;

  typedef enum logic [1:0] {
    LLC_I = 2'd0,
    LLC_S = 2'd1,
    LLC_U = 2'd2
  } llc_kind_t;

  typedef enum logic [1:0] {
    PF_CLEAR = 2'd0,
    PF_POLL  = 2'd1,
    PF_FINAL = 2'd2
  } poll_final_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    frame_class_t frame_class;
    logic [15:0]  length_or_type;
    logic [5:0]   ip_header_bytes;
    logic [7:0]   ip_protocol;
    logic         checksum_ok;
    icmp_class_t  icmp_class;
    llc_kind_t    llc_kind;
    logic [6:0]   llc_send_number;
    logic [6:0]   llc_receive_number;
    logic [4:0]   llc_modifier;
    poll_final_t  llc_poll_final;
    logic [15:0]  arp_operation;
  } result_t;

endpackage

// File: rtl/core/ethernet_header_classifier_core.sv
// ethernet header classifier: streams frame bytes, emits one summary per frame
//
// input transaction: one frame byte (destination mac first) with in_last_byte
// high on the final byte. one output transaction follows each frame, carrying
// the frame class, length/type word, ipv4 header length, protocol, checksum
// check, icmp class, llc control decode and arp operation.
// bytes flow through an input register, the field capture and decode logic,
// and a result register. out_valid rises when the result register loads the
// summary decoded from the last byte. one byte is taken every cycle unless a
// last byte waits for room in the result register; a non-final byte never
// waits on the output side. bytes past the frame limit are counted as nothing.
// when the receiver stalls, the result register holds; bytes of the next
// frame keep flowing until its last byte reaches the input register, which
// then waits there, with in_ready low, until the result is taken.
// reset (rst_n low at a clock edge) drops any partial frame and pending
// result and clears all frame state; no clearing pass is needed afterward.
module ethernet_header_classifier_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_frame_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_frame_class,
  output logic [15:0] out_length_or_type,
  output logic [5:0]  out_ip_header_bytes,
  output logic [7:0]  out_ip_protocol,
  output logic        out_checksum_ok,
  output logic [2:0]  out_icmp_class,
  output logic [1:0]  out_llc_kind,
  output logic [6:0]  out_llc_send_number,
  output logic [6:0]  out_llc_receive_number,
  output logic [4:0]  out_llc_modifier,
  output logic [1:0]  out_llc_poll_final,
  output logic [15:0] out_arp_operation
);
  import ehc_pkg::*;

  in_item_t in_item;
  in_item_t item;
  logic     item_valid;
  logic     advance;
  logic     can_load;
  result_t  result;
  result_t  out_result;

  assign in_item.frame_byte = in_frame_byte;
  assign in_item.last_byte  = in_last_byte;

  // only a last byte needs room in the result register
  assign advance = item_valid && (!item.last_byte || can_load);

  ehc_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  ehc_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (item),
    .result (result)
  );

  ehc_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance && item.last_byte),
    .result     (result),
    .can_load   (can_load),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_result (out_result)
  );

  assign out_frame_class        = out_result.frame_class;
  assign out_length_or_type     = out_result.length_or_type;
  assign out_ip_header_bytes    = out_result.ip_header_bytes;
  assign out_ip_protocol        = out_result.ip_protocol;
  assign out_checksum_ok        = out_result.checksum_ok;
  assign out_icmp_class         = out_result.icmp_class;
  assign out_llc_kind           = out_result.llc_kind;
  assign out_llc_send_number    = out_result.llc_send_number;
  assign out_llc_receive_number = out_result.llc_receive_number;
  assign out_llc_modifier       = out_result.llc_modifier;
  assign out_llc_poll_final     = out_result.llc_poll_final;
  assign out_arp_operation      = out_result.arp_operation;

endmodule

// File: rtl/core/ehc_in_stage.sv
// input register holding one frame byte ahead of the parser
module ehc_in_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  ehc_pkg::in_item_t in_item,
  input  logic             advance,
  output logic             item_valid,
  output ehc_pkg::in_item_t item
);
  import ehc_pkg::*;

  logic     valid_r;
  in_item_t item_r;

  assign in_ready   = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

// File: rtl/core/ehc_parser.sv
// frame state, per-byte field capture and summary decode
module ehc_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  ehc_pkg::in_item_t item,
  output ehc_pkg::result_t  result
);
  import ehc_pkg::*;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_BYTES);
  localparam logic [CNT_W-1:0] P_TYPE_HI = CNT_W'(12);
  localparam logic [CNT_W-1:0] P_TYPE_LO = CNT_W'(13);
  localparam logic [CNT_W-1:0] P_HDR     = CNT_W'(14);
  localparam logic [CNT_W-1:0] P_SSAP    = CNT_W'(15);
  localparam logic [CNT_W-1:0] P_CTRL1   = CNT_W'(16);
  localparam logic [CNT_W-1:0] P_CTRL2   = CNT_W'(17);
  localparam logic [CNT_W-1:0] P_LLC_END = CNT_W'(18);
  localparam logic [CNT_W-1:0] P_ARP_HI  = CNT_W'(20);
  localparam logic [CNT_W-1:0] P_ARP_LO  = CNT_W'(21);
  localparam logic [CNT_W-1:0] P_ARP_END = CNT_W'(22);
  localparam logic [CNT_W-1:0] P_PROTO   = CNT_W'(23);
  localparam logic [CNT_W-1:0] P_CSUM_HI = CNT_W'(24);
  localparam logic [CNT_W-1:0] P_CSUM_LO = CNT_W'(25);
  localparam logic [CNT_W-1:0] P_IP_MIN  = CNT_W'(26);
  localparam logic [CNT_W-1:0] Q_CSUM    = CNT_W'(11);

  logic [CNT_W-1:0] byte_count_r, byte_count_nxt, byte_count_upd;
  logic [15:0]      type_word_r, type_word_nxt, type_word_upd;
  logic [3:0]       hdr_words_r, hdr_words_nxt, hdr_words_upd;
  logic [20:0]      sum_r, sum_nxt, sum_upd;
  logic [7:0]       pend_r, pend_nxt, pend_upd;
  logic [15:0]      csum_r, csum_nxt, csum_upd;
  logic [7:0]       proto_r, proto_nxt, proto_upd;
  logic [15:0]      icmp_tc_r, icmp_tc_nxt, icmp_tc_upd;
  logic [23:0]      llc_r, llc_nxt, llc_upd;
  logic [15:0]      arp_op_r, arp_op_nxt, arp_op_upd;

  logic [CNT_W-1:0] p;
  logic [CNT_W-1:0] q;
  logic [CNT_W-1:0] hl_ext;
  logic [5:0]       hl;
  logic [7:0]       b;
  logic [CNT_W-1:0] need;
  logic [16:0]      fold1;
  logic [15:0]      fold2;
  logic [7:0]       ctl1, ctl2, icmp_t, icmp_c;
  logic             pf_bit;
  result_t          res;

  // frame state with this byte absorbed
  always_comb begin
    byte_count_upd = byte_count_r;
    type_word_upd  = type_word_r;
    hdr_words_upd  = hdr_words_r;
    sum_upd        = sum_r;
    pend_upd       = pend_r;
    csum_upd       = csum_r;
    proto_upd      = proto_r;
    icmp_tc_upd    = icmp_tc_r;
    llc_upd        = llc_r;
    arp_op_upd     = arp_op_r;
    p  = byte_count_r;
    b  = item.frame_byte;
    q  = p - P_HDR;
    if (step && (p == P_HDR)) begin
      hdr_words_upd = b[3:0];
    end
    hl     = {hdr_words_upd, 2'b00};
    hl_ext = CNT_W'(hl);
    if (step && (p < CNT_MAX)) begin
      byte_count_upd = p + CNT_W'(1);
      if (p == P_TYPE_HI) begin
        type_word_upd = {b, 8'h00};
      end else if (p == P_TYPE_LO) begin
        type_word_upd = {type_word_r[15:8], b};
      end else if (p >= P_HDR) begin
        if (type_word_r == TYPE_IPV4) begin
          if (!q[0]) begin
            pend_upd = b;
          end else if ((q < hl_ext) && (q != Q_CSUM)) begin
            sum_upd = sum_r + {5'd0, pend_r, b};
          end
          if (p == P_PROTO) proto_upd = b;
          if (p == P_CSUM_HI) csum_upd[15:8] = b;
          if (p == P_CSUM_LO) csum_upd[7:0] = b;
          if (p == P_HDR + hl_ext) icmp_tc_upd[15:8] = b;
          if (p == P_SSAP + hl_ext) icmp_tc_upd[7:0] = b;
        end else if (type_word_r < LLC_LIMIT) begin
          if (p == P_SSAP) llc_upd[23:16] = b;
          if (p == P_CTRL1) llc_upd[15:8] = b;
          if (p == P_CTRL2) llc_upd[7:0] = b;
        end else if (type_word_r == TYPE_ARP) begin
          if (p == P_ARP_HI) arp_op_upd[15:8] = b;
          if (p == P_ARP_LO) arp_op_upd[7:0] = b;
        end
      end
    end
  end

  // next frame state
  always_comb begin
    byte_count_nxt = byte_count_upd;
    type_word_nxt  = type_word_upd;
    hdr_words_nxt  = hdr_words_upd;
    sum_nxt        = sum_upd;
    pend_nxt       = pend_upd;
    csum_nxt       = csum_upd;
    proto_nxt      = proto_upd;
    icmp_tc_nxt    = icmp_tc_upd;
    llc_nxt        = llc_upd;
    arp_op_nxt     = arp_op_upd;
    // frame over: start clean for the next one
    if (step && item.last_byte) begin
      byte_count_nxt = '0;
      type_word_nxt  = '0;
      hdr_words_nxt  = '0;
      sum_nxt        = '0;
      pend_nxt       = '0;
      csum_nxt       = '0;
      proto_nxt      = '0;
      icmp_tc_nxt    = '0;
      llc_nxt        = '0;
      arp_op_nxt     = '0;
    end
  end

  // summary decode, taken from the state as updated by this byte
  always_comb begin
    res = '0;
    res.length_or_type = type_word_upd;
    res.icmp_class     = ICMP_OTHER;
    res.frame_class    = FC_OTHER;
    ctl1   = llc_upd[15:8];
    ctl2   = llc_upd[7:0];
    pf_bit = 1'b0;
    icmp_t = icmp_tc_upd[15:8];
    icmp_c = icmp_tc_upd[7:0];
    // ip header must reach past the checksum, and past type/code for icmp
    if (proto_upd == PROTO_ICMP) begin
      need = (hl_ext >= CNT_W'(10)) ? (P_CTRL1 + hl_ext) : P_IP_MIN;
    end else begin
      need = (hl_ext >= CNT_W'(12)) ? (P_HDR + hl_ext) : P_IP_MIN;
    end
    fold1 = {1'b0, sum_upd[15:0]} + {12'd0, sum_upd[20:16]};
    fold2 = fold1[15:0] + {15'd0, fold1[16]};
    if (byte_count_upd < P_HDR) begin
      res.frame_class = FC_TRUNC;
    end else if (type_word_upd < LLC_LIMIT) begin
      if (byte_count_upd < P_LLC_END) begin
        res.frame_class = FC_TRUNC;
      end else begin
        res.frame_class = FC_LLC;
        case (ctl1[1:0])
          2'b01: begin
            res.llc_kind           = LLC_S;
            res.llc_receive_number = ctl2[7:1];
            res.llc_modifier       = {3'd0, ctl1[3:2]};
            pf_bit                 = ctl2[0];
          end
          2'b11: begin
            res.llc_kind     = LLC_U;
            res.llc_modifier = {ctl1[7:5], ctl1[3:2]};
            pf_bit           = ctl1[4];
          end
          default: begin
            res.llc_kind           = LLC_I;
            res.llc_send_number    = ctl1[7:1];
            res.llc_receive_number = ctl2[7:1];
            pf_bit                 = ctl2[0];
          end
        endcase
        if (pf_bit) begin
          res.llc_poll_final = llc_upd[16] ? PF_FINAL : PF_POLL;
        end
      end
    end else if (type_word_upd == TYPE_IPV4) begin
      if (byte_count_upd < need) begin
        res.frame_class = FC_TRUNC;
      end else begin
        res.frame_class     = FC_IPV4;
        res.ip_header_bytes = hl;
        res.ip_protocol     = proto_upd;
        res.checksum_ok     = ((~fold2) == csum_upd);
        if (proto_upd == PROTO_ICMP) begin
          if (icmp_t == 8'd8 && icmp_c == 8'd0) begin
            res.icmp_class = ICMP_ECHO_REQ;
          end else if (icmp_t == 8'd0 && icmp_c == 8'd0) begin
            res.icmp_class = ICMP_ECHO_REPLY;
          end else if (icmp_t == 8'd3 && icmp_c <= 8'd3) begin
            res.icmp_class = ICMP_UNREACH_LOW;
          end else if (icmp_t == 8'd3 && icmp_c <= 8'd13) begin
            res.icmp_class = ICMP_UNREACH_HIGH;
          end else if (icmp_t == 8'd11 && icmp_c <= 8'd1) begin
            res.icmp_class = ICMP_TIME_EXCEED;
          end else begin
            res.icmp_class = ICMP_OTHER;
          end
        end
      end
    end else if (type_word_upd == TYPE_ARP) begin
      if (byte_count_upd < P_ARP_END) begin
        res.frame_class = FC_TRUNC;
      end else begin
        res.frame_class   = FC_ARP;
        res.arp_operation = arp_op_upd;
      end
    end
  end

  assign result = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      type_word_r  <= '0;
      hdr_words_r  <= '0;
      sum_r        <= '0;
      pend_r       <= '0;
      csum_r       <= '0;
      proto_r      <= '0;
      icmp_tc_r    <= '0;
      llc_r        <= '0;
      arp_op_r     <= '0;
    end else begin
      byte_count_r <= byte_count_nxt;
      type_word_r  <= type_word_nxt;
      hdr_words_r  <= hdr_words_nxt;
      sum_r        <= sum_nxt;
      pend_r       <= pend_nxt;
      csum_r       <= csum_nxt;
      proto_r      <= proto_nxt;
      icmp_tc_r    <= icmp_tc_nxt;
      llc_r        <= llc_nxt;
      arp_op_r     <= arp_op_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r <= CNT_MAX)
    else $error("byte count beyond frame limit");

  a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    step && item.last_byte |=> byte_count_r == '0 && type_word_r == '0)
    else $error("frame state not cleared after last byte");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    step && !item.last_byte && byte_count_r < CNT_MAX
      |=> byte_count_r == $past(byte_count_r) + CNT_W'(1))
    else $error("byte count did not advance");

  a_icmp_only_ipv4: assert property (@(posedge clk) disable iff (!rst_n)
    res.frame_class != FC_IPV4 |-> res.icmp_class == ICMP_OTHER)
    else $error("icmp class outside an ipv4 frame");
`endif

endmodule

// File: rtl/core/ehc_out_stage.sv
// result register toward the downstream receiver
module ehc_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  ehc_pkg::result_t result,
  output logic             can_load,
  output logic             out_valid,
  input  logic             out_ready,
  output ehc_pkg::result_t out_result
);
  import ehc_pkg::*;

  logic    valid_r;
  result_t result_r;

  assign can_load   = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign out_result = result_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      result_r <= result;
    end
  end

endmodule

// File: tb/testbench.sv
// self-checking testbench for the ethernet header classifier core
`timescale 1ns / 1ps

module testbench;
  import ehc_pkg::*;

  localparam int IDLE_LIMIT = 500;
  localparam int TOTAL_BYTES = 1100;

  // frame state mirror and store of expected frame summaries
  class frame_summary_checker;
    result_t     expected_summaries[$];
    int          mismatches;
    int          frames_checked;
    int          class_hits[5];
    int          csum_good;
    int          csum_bad;
    int unsigned byte_cnt;
    logic [15:0] type_word;
    logic [3:0]  ihl;
    logic [20:0] word_sum;
    logic [7:0]  high_byte;
    logic [15:0] stored_csum;
    logic [7:0]  proto;
    logic [15:0] icmp_tc;
    logic [23:0] llc_bytes;
    logic [15:0] arp_op;

    function new();
      clear_frame();
    endfunction

    function void clear_frame();
      byte_cnt    = 0;
      type_word   = '0;
      ihl         = '0;
      word_sum    = '0;
      high_byte   = '0;
      stored_csum = '0;
      proto       = '0;
      icmp_tc     = '0;
      llc_bytes   = '0;
      arp_op      = '0;
    endfunction

    function void capture_header_byte(int unsigned p, logic [7:0] b);
      int unsigned q;
      int unsigned hl;
      if (p == 12) begin
        type_word = {b, 8'h00};
        return;
      end
      if (p == 13) begin
        type_word[7:0] = b;
        return;
      end
      if (p < 14) return;
      if (type_word == TYPE_IPV4) begin
        q = p - 14;
        if (p == 14) ihl = b[3:0];
        hl = int'(ihl) * 4;
        // odd offsets close a 16-bit word; the checksum word itself is skipped
        if (q[0] == 1'b0) high_byte = b;
        else if (q < hl && q != 11) word_sum = word_sum + {high_byte, b};
        if (p == 23) proto = b;
        if (p == 24) stored_csum[15:8] = b;
        if (p == 25) stored_csum[7:0] = b;
        if (p == 14 + hl) icmp_tc[15:8] = b;
        if (p == 15 + hl) icmp_tc[7:0] = b;
      end else if (type_word < LLC_LIMIT) begin
        if (p == 15) llc_bytes[23:16] = b;
        if (p == 16) llc_bytes[15:8] = b;
        if (p == 17) llc_bytes[7:0] = b;
      end else if (type_word == TYPE_ARP) begin
        if (p == 20) arp_op[15:8] = b;
        if (p == 21) arp_op[7:0] = b;
      end
    endfunction

    function icmp_class_t icmp_kind(logic [15:0] tc);
      logic [7:0] t;
      logic [7:0] c;
      t = tc[15:8];
      c = tc[7:0];
      if (t == 8 && c == 0) return ICMP_ECHO_REQ;
      if (t == 0 && c == 0) return ICMP_ECHO_REPLY;
      if (t == 3 && c <= 3) return ICMP_UNREACH_LOW;
      if (t == 3 && c <= 13) return ICMP_UNREACH_HIGH;
      if (t == 11 && c <= 1) return ICMP_TIME_EXCEED;
      return ICMP_OTHER;
    endfunction

    function result_t summarize_frame();
      result_t     r;
      int unsigned hl;
      int unsigned need;
      logic [16:0] s;
      logic [15:0] csum;
      logic [7:0]  ssap;
      logic [7:0]  c1;
      logic [7:0]  c2;
      logic        pf;
      r = '0;
      r.length_or_type = type_word;
      r.icmp_class = ICMP_OTHER;
      r.frame_class = FC_TRUNC;
      if (byte_cnt < 14) return r;
      if (type_word < LLC_LIMIT) begin
        if (byte_cnt < 18) return r;
        ssap = llc_bytes[23:16];
        c1 = llc_bytes[15:8];
        c2 = llc_bytes[7:0];
        r.frame_class = FC_LLC;
        case (c1[1:0])
          2'b01: begin
            r.llc_kind = LLC_S;
            r.llc_receive_number = c2[7:1];
            r.llc_modifier = {3'b000, c1[3:2]};
            pf = c2[0];
          end
          2'b11: begin
            r.llc_kind = LLC_U;
            r.llc_modifier = {c1[7:5], c1[3:2]};
            pf = c1[4];
          end
          default: begin
            r.llc_kind = LLC_I;
            r.llc_send_number = c1[7:1];
            r.llc_receive_number = c2[7:1];
            pf = c2[0];
          end
        endcase
        // ssap bit 0 tells a response from a command
        r.llc_poll_final = !pf ? PF_CLEAR : (ssap[0] ? PF_FINAL : PF_POLL);
      end else if (type_word == TYPE_IPV4) begin
        hl = int'(ihl) * 4;
        need = 14 + hl;
        if (need < 26) need = 26;
        if (proto == PROTO_ICMP && need < 16 + hl) need = 16 + hl;
        if (byte_cnt < need) return r;
        s = word_sum[15:0] + word_sum[20:16];
        s = s[15:0] + s[16];
        csum = ~s[15:0];
        r.frame_class = FC_IPV4;
        r.ip_header_bytes = hl[5:0];
        r.ip_protocol = proto;
        r.checksum_ok = (csum == stored_csum);
        if (proto == PROTO_ICMP) r.icmp_class = icmp_kind(icmp_tc);
      end else if (type_word == TYPE_ARP) begin
        if (byte_cnt < 22) return r;
        r.frame_class = FC_ARP;
        r.arp_operation = arp_op;
      end else begin
        r.frame_class = FC_OTHER;
      end
      return r;
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      // bytes past the frame limit are dropped
      if (byte_cnt < MAX_FRAME_BYTES) begin
        capture_header_byte(byte_cnt, b);
        byte_cnt++;
      end
      if (last) begin
        expected_summaries.push_back(summarize_frame());
        clear_frame();
      end
    endfunction

    function void compare_field(string name, logic [15:0] want_v, logic [15:0] got_v);
      if (want_v !== got_v) begin
        $error("%s expected %0d actual %0d", name, want_v, got_v);
        mismatches++;
      end
    endfunction

    function void check_summary(result_t got);
      result_t want;
      if (expected_summaries.size() == 0) begin
        $error("summary with no frame outstanding, frame_class actual %0d", got.frame_class);
        mismatches++;
        return;
      end
      want = expected_summaries.pop_front();
      frames_checked++;
      class_hits[want.frame_class]++;
      if (want.frame_class == FC_IPV4) begin
        if (want.checksum_ok) csum_good++;
        else csum_bad++;
      end
      compare_field("frame_class", want.frame_class, got.frame_class);
      compare_field("length_or_type", want.length_or_type, got.length_or_type);
      compare_field("ip_header_bytes", want.ip_header_bytes, got.ip_header_bytes);
      compare_field("ip_protocol", want.ip_protocol, got.ip_protocol);
      compare_field("checksum_ok", want.checksum_ok, got.checksum_ok);
      compare_field("icmp_class", want.icmp_class, got.icmp_class);
      compare_field("llc_kind", want.llc_kind, got.llc_kind);
      compare_field("llc_send_number", want.llc_send_number, got.llc_send_number);
      compare_field("llc_receive_number", want.llc_receive_number, got.llc_receive_number);
      compare_field("llc_modifier", want.llc_modifier, got.llc_modifier);
      compare_field("llc_poll_final", want.llc_poll_final, got.llc_poll_final);
      compare_field("arp_operation", want.arp_operation, got.arp_operation);
    endfunction

    function int pending();
      return expected_summaries.size();
    endfunction

    function void flag_leftovers();
      if (expected_summaries.size() != 0) begin
        $error("%0d frame summaries never arrived", expected_summaries.size());
        mismatches++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_frame_byte = '0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_frame_class;
  logic [15:0] out_length_or_type;
  logic [5:0]  out_ip_header_bytes;
  logic [7:0]  out_ip_protocol;
  logic        out_checksum_ok;
  logic [2:0]  out_icmp_class;
  logic [1:0]  out_llc_kind;
  logic [6:0]  out_llc_send_number;
  logic [6:0]  out_llc_receive_number;
  logic [4:0]  out_llc_modifier;
  logic [1:0]  out_llc_poll_final;
  logic [15:0] out_arp_operation;

  frame_summary_checker summary_chk = new();
  logic [7:0] frame_q[$];
  int         bytes_sent;
  int         send_gap_max = 3;
  int         recv_gap_max = 3;
  int         idle_cycles;

  ethernet_header_classifier_core uut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_frame_byte          (in_frame_byte),
    .in_last_byte           (in_last_byte),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_frame_class        (out_frame_class),
    .out_length_or_type     (out_length_or_type),
    .out_ip_header_bytes    (out_ip_header_bytes),
    .out_ip_protocol        (out_ip_protocol),
    .out_checksum_ok        (out_checksum_ok),
    .out_icmp_class         (out_icmp_class),
    .out_llc_kind           (out_llc_kind),
    .out_llc_send_number    (out_llc_send_number),
    .out_llc_receive_number (out_llc_receive_number),
    .out_llc_modifier       (out_llc_modifier),
    .out_llc_poll_final     (out_llc_poll_final),
    .out_arp_operation      (out_arp_operation)
  );

  always #1 clk = ~clk;

  // mac addresses then the length/type word
  function void start_frame(logic [15:0] lt);
    frame_q.delete();
    repeat (12) frame_q.push_back(8'($urandom_range(0, 255)));
    frame_q.push_back(lt[15:8]);
    frame_q.push_back(lt[7:0]);
  endfunction

  function void push_random(int n);
    repeat (n) frame_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  function void build_fill(logic [7:0] b, int n);
    frame_q.delete();
    repeat (n) frame_q.push_back(b);
  endfunction

  function void build_llc(logic [15:0] lt, logic [7:0] ssap, logic [7:0] c1,
                          logic [7:0] c2, int extra);
    start_frame(lt);
    push_random(1);
    frame_q.push_back(ssap);
    frame_q.push_back(c1);
    frame_q.push_back(c2);
    push_random(extra);
  endfunction

  function void build_arp(logic [15:0] op, int extra);
    start_frame(TYPE_ARP);
    push_random(6);
    frame_q.push_back(op[15:8]);
    frame_q.push_back(op[7:0]);
    push_random(extra);
  endfunction

  function void build_ipv4(int ihl, logic [7:0] proto, logic [15:0] icmp_tc,
                           bit good_csum, int extra);
    logic [7:0]  hdr[$];
    int          hl;
    int          span;
    logic [31:0] acc;
    logic [15:0] csum;
    hl = ihl * 4;
    span = (hl > 20) ? hl : 20;
    start_frame(TYPE_IPV4);
    repeat (span + 2 + extra) hdr.push_back(8'($urandom_range(0, 255)));
    hdr[0] = {4'h4, 4'(ihl)};
    hdr[9] = proto;
    hdr[10] = '0;
    hdr[11] = '0;
    // short headers keep the icmp bytes where they fall inside the fixed fields
    if (hl >= 12) begin
      hdr[hl] = icmp_tc[15:8];
      hdr[hl + 1] = icmp_tc[7:0];
    end
    acc = '0;
    for (int i = 0; i + 1 < hl; i += 2) begin
      if (i != 10) acc += {hdr[i], hdr[i + 1]};
    end
    acc = acc[15:0] + acc[31:16];
    acc = acc[15:0] + acc[31:16];
    csum = ~acc[15:0];
    if (!good_csum) csum ^= 16'($urandom_range(1, 65535));
    hdr[10] = csum[15:8];
    hdr[11] = csum[7:0];
    foreach (hdr[i]) frame_q.push_back(hdr[i]);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_frame_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (!in_ready);
    summary_chk.note_byte(b, last);
    bytes_sent++;
  endtask

  // cut of zero sends the whole frame, otherwise only its first cut bytes
  task automatic send_frame(input int cut);
    int n;
    n = frame_q.size();
    if (cut > 0 && cut < n) n = cut;
    for (int i = 0; i < n; i++) send_byte(frame_q[i], i == n - 1);
  endtask

  task automatic wait_all_summaries();
    in_valid <= 1'b0;
    do @(posedge clk); while (summary_chk.pending() != 0);
  endtask

  task automatic send_random_frame();
    int          pick;
    int          ihl;
    int          roll;
    logic [7:0]  proto;
    logic [15:0] tc;
    logic [15:0] icmp_pairs[8];
    icmp_pairs = '{16'h0800, 16'h0000, 16'h0303, 16'h0304,
                   16'h030D, 16'h030E, 16'h0B01, 16'h0B02};
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      roll = $urandom_range(0, 9);
      ihl = (roll < 7) ? 5 : (roll < 9) ? $urandom_range(6, 15) : $urandom_range(0, 4);
      roll = $urandom_range(0, 9);
      proto = (roll < 5) ? PROTO_ICMP : (roll < 7) ? 8'd6 : (roll < 8) ? 8'd17 :
              8'($urandom_range(0, 255));
      tc = ($urandom_range(0, 9) < 6) ? icmp_pairs[$urandom_range(0, 7)] :
           16'($urandom_range(0, 65535));
      build_ipv4(ihl, proto, tc, $urandom_range(0, 4) != 0, $urandom_range(0, 24));
    end else if (pick < 60) begin
      roll = $urandom_range(0, 9);
      tc = (roll == 0) ? 16'd0 : (roll == 1) ? 16'(LLC_LIMIT - 1) :
           16'($urandom_range(0, LLC_LIMIT - 1));
      build_llc(tc, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), $urandom_range(0, 10));
    end else if (pick < 75) begin
      tc = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(1, 4)) :
           16'($urandom_range(0, 65535));
      build_arp(tc, $urandom_range(0, 28));
    end else if (pick < 85) begin
      start_frame(16'($urandom_range(LLC_LIMIT, 65535)));
      push_random($urandom_range(0, 30));
    end else begin
      frame_q.delete();
      push_random($urandom_range(1, 40));
    end
    if ($urandom_range(0, 6) == 0) send_frame($urandom_range(1, frame_q.size()));
    else send_frame(0);
  endtask

  // receiver: random back-pressure with calm stretches
  initial begin
    int stall;
    do @(posedge clk); while (!rst_n);
    forever begin
      if ($urandom_range(0, 7) == 0) recv_gap_max = (recv_gap_max == 0) ? 3 : 0;
      stall = $urandom_range(0, recv_gap_max);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      summary_chk.check_summary({out_frame_class, out_length_or_type, out_ip_header_bytes,
                                 out_ip_protocol, out_checksum_ok, out_icmp_class,
                                 out_llc_kind, out_llc_send_number, out_llc_receive_number,
                                 out_llc_modifier, out_llc_poll_final, out_arp_operation});
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", idle_cycles);
      $display("ethernet_header_classifier_core regression: fail");
      $finish;
    end
  end

  initial begin
    logic [15:0] icmp_pairs[8];
    icmp_pairs = '{16'h0800, 16'h0000, 16'h0303, 16'h0304,
                   16'h030D, 16'h030E, 16'h0B01, 16'h0B02};
    idle_cycles = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single byte and headers cut short
    start_frame(16'h0000);
    send_frame(1);
    start_frame(TYPE_IPV4);
    send_frame(0);
    build_arp(16'h0001, 0);
    send_frame(13);
    // all-zero and all-ones frames
    build_fill(8'h00, 20);
    send_frame(0);
    build_fill(8'hFF, 20);
    send_frame(0);
    // llc i, s and u frames, poll and final
    build_llc(16'(LLC_LIMIT - 1), 8'h00, 8'hFE, 8'hFF, 0);
    send_frame(0);
    build_llc(16'd46, 8'h01, 8'h0D, 8'h81, 4);
    send_frame(0);
    build_llc(16'd3, 8'hFF, 8'hFF, 8'h00, 0);
    send_frame(0);
    build_llc(16'd3, 8'h42, 8'h03, 8'h00, 2);
    send_frame(0);
    build_llc(16'd10, 8'h00, 8'h00, 8'h01, 0);
    send_frame(17);
    // length word of exactly 1500 is not llc
    start_frame(LLC_LIMIT);
    push_random(10);
    send_frame(0);
    build_arp(16'h0001, 4);
    send_frame(0);
    build_arp(16'hFFFF, 0);
    send_frame(0);
    build_arp(16'h0002, 0);
    send_frame(21);
    foreach (icmp_pairs[i]) begin
      build_ipv4(5, PROTO_ICMP, icmp_pairs[i], 1'b1, 0);
      send_frame(0);
    end
    build_ipv4(5, 8'd6, 16'h0000, 1'b0, 2);
    send_frame(0);
    // widest header, then one byte short of its icmp code
    build_ipv4(15, PROTO_ICMP, 16'h0800, 1'b1, 0);
    send_frame(0);
    build_ipv4(15, PROTO_ICMP, 16'h0800, 1'b1, 0);
    send_frame(75);
    // header lengths below the minimum
    build_ipv4(0, 8'd17, 16'h0000, 1'b1, 4);
    send_frame(0);
    build_ipv4(3, PROTO_ICMP, 16'h0000, 1'b1, 6);
    send_frame(0);
    wait_all_summaries();

    while (bytes_sent < TOTAL_BYTES) begin
      if ($urandom_range(0, 3) == 0) send_gap_max = (send_gap_max == 0) ? 3 : 0;
      if ($urandom_range(0, 9) == 0) wait_all_summaries();
      send_random_frame();
    end
    wait_all_summaries();
    repeat (8) @(posedge clk);
    summary_chk.flag_leftovers();

    $display("checked %0d frame summaries from %0d bytes: llc %0d, ipv4 %0d, arp %0d,",
             summary_chk.frames_checked, bytes_sent, summary_chk.class_hits[FC_LLC],
             summary_chk.class_hits[FC_IPV4], summary_chk.class_hits[FC_ARP]);
    $display("other %0d, truncated %0d; ipv4 checksum good %0d bad %0d; %0d mismatches",
             summary_chk.class_hits[FC_OTHER], summary_chk.class_hits[FC_TRUNC],
             summary_chk.csum_good, summary_chk.csum_bad, summary_chk.mismatches);
    if (summary_chk.mismatches == 0) begin
      $display("ethernet_header_classifier_core regression: pass");
    end else begin
      $display("ethernet_header_classifier_core regression: fail");
    end
    $finish;
  end

endmodule
